>>> rtl/core/scc_pkg.sv
package scc_pkg;

  // default sizes
  localparam int SLOTS_DEF       = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // fixed field widths
  localparam int SECTOR_W = 32;
  localparam int CHUNK_W  = 28;
  localparam int OFF_W    = 4;
  localparam int SLOT_W   = 6;
  localparam int RCNT_W   = 5;
  localparam int REQ_W    = 2;
  localparam int OC_W     = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [RCNT_W-1:0] CHUNK_LEN  = 5'd16;
  localparam int                FILL_COUNT = 1000;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FILL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INVAL  = 2'd2;

  // result kinds
  localparam logic [OC_W-1:0] OC_HIT   = 2'd0;
  localparam logic [OC_W-1:0] OC_MISS  = 2'd1;
  localparam logic [OC_W-1:0] OC_FILL  = 2'd2;
  localparam logic [OC_W-1:0] OC_INVAL = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic rd;
    logic age;
    logic resolve;
    logic fill;
    logic inval;
    logic drop_pend;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             read_ok;
    logic             pend_valid;
    logic             idx_last;
    logic             hit;
    logic             can_push;
  } sts_t;

endpackage

>>> rtl/core/scc_ctrl.sv
module scc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  scc_pkg::sts_t sts,
  output scc_pkg::cmd_t cmd
);
  import scc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_END,
    S_RESOLVE,
    S_AGE,
    S_AGE_END,
    S_FILL,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_LOOKUP: begin
            cmd.clr   = 1'b1;
            state_nxt = S_SCAN;
          end
          REQ_FILL: begin
            if (!sts.pend_valid) begin
              state_nxt = S_IDLE;
            end else if (sts.read_ok) begin
              state_nxt = S_FILL;
            end else begin
              cmd.inval     = 1'b1;
              cmd.drop_pend = 1'b1;
              state_nxt     = S_OUT;
            end
          end
          REQ_INVAL: begin
            cmd.inval = 1'b1;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: state_nxt = S_RESOLVE;
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        cmd.clr     = 1'b1;
        state_nxt   = sts.hit ? S_AGE : S_OUT;
      end
      S_AGE: begin
        cmd.rd  = 1'b1;
        cmd.age = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_AGE_END;
        end
      end
      S_AGE_END: state_nxt = S_OUT;
      S_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.can_push) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

>>> rtl/core/scc_dp.sv
module scc_dp #(
  parameter int SLOTS       = scc_pkg::SLOTS_DEF,
  parameter int COUNT_WIDTH = scc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scc_pkg::cmd_t                       cmd,
  output scc_pkg::sts_t                       sts,
  input  logic [scc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [scc_pkg::REQ_W-1:0]           in_tuser,
  input  logic [scc_pkg::SECTOR_W-1:0]        volume_sectors,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [scc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [scc_pkg::OC_W-1:0]            out_tuser
);
  import scc_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDXW-1:0]        IDX_LAST = IDXW'(SLOTS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_FILL = COUNT_WIDTH'(FILL_COUNT);

  // captured request
  logic [REQ_W-1:0]    req_r;
  logic [SECTOR_W-1:0] sector_r;
  logic                ok_r;
  logic [CHUNK_W-1:0]  chunk;
  logic [OFF_W-1:0]    offset;

  assign chunk  = sector_r[SECTOR_W-1:OFF_W];
  assign offset = sector_r[OFF_W-1:0];

  // tag and count stores
  logic [CHUNK_W-1:0]     tag_mem [SLOTS];
  logic [COUNT_WIDTH-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0]       tag_valid_r;
  logic [SLOTS-1:0]       cnt_init_r;

  // scan pipeline
  logic [IDXW-1:0]        idx_r;
  logic                   rd_v_r;
  logic                   rd_age_r;
  logic [IDXW-1:0]        rd_idx_r;
  logic [CHUNK_W-1:0]     tag_q;
  logic [COUNT_WIDTH-1:0] cnt_raw_q;
  logic                   cnt_init_q;
  logic                   valid_q;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_aged;

  // scan results
  logic                   hit_r;
  logic [IDXW-1:0]        hit_slot_r;
  logic                   free_r;
  logic [IDXW-1:0]        free_slot_r;
  logic [COUNT_WIDTH-1:0] min_r;
  logic [IDXW-1:0]        min_slot_r;

  // outstanding miss
  logic [CHUNK_W-1:0] pend_chunk_r;
  logic [IDXW-1:0]    pend_slot_r;
  logic [OFF_W-1:0]   pend_off_r;
  logic               pend_valid_r;

  // result and output register
  logic [OC_W-1:0]     res_oc_r;
  logic [IDXW-1:0]     res_slot_r;
  logic [OFF_W-1:0]    res_off_r;
  logic [SECTOR_W-1:0] res_start_r;
  logic [RCNT_W-1:0]   res_cnt_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OC_W-1:0]     out_user_r;

  // miss read range
  logic [SECTOR_W-1:0] miss_start;
  logic [SECTOR_W-1:0] miss_diff;
  logic [RCNT_W-1:0]   miss_cnt;
  logic [IDXW-1:0]     victim;

  logic                   age_we;
  logic                   cnt_we;
  logic [IDXW-1:0]        cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;

  assign cnt_cur = cnt_init_q ? cnt_raw_q : '0;

  always_comb begin
    if (rd_idx_r == hit_slot_r) begin
      cnt_aged = (cnt_cur != CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
    end else begin
      cnt_aged = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
    end
  end

  assign miss_start = {chunk, {OFF_W{1'b0}}};
  assign miss_diff  = volume_sectors - miss_start;
  assign victim     = free_r ? free_slot_r : min_slot_r;

  always_comb begin
    if (volume_sectors == '0) begin
      miss_cnt = CHUNK_LEN;
    end else if (volume_sectors <= miss_start) begin
      miss_cnt = '0;
    end else if (miss_diff < SECTOR_W'(CHUNK_LEN)) begin
      miss_cnt = miss_diff[RCNT_W-1:0];
    end else begin
      miss_cnt = CHUNK_LEN;
    end
  end

  assign age_we = rd_v_r && rd_age_r;
  assign cnt_we = age_we || cmd.fill;
  assign cnt_wa = cmd.fill ? pend_slot_r : rd_idx_r;
  assign cnt_wd = cmd.fill ? CNT_FILL : cnt_aged;

  // stores: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag_mem[pend_slot_r] <= pend_chunk_r;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.rd) begin
      tag_q     <= tag_mem[idx_r];
      cnt_raw_q <= cnt_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r  <= '0;
      cnt_init_r   <= '0;
      idx_r        <= '0;
      rd_v_r       <= 1'b0;
      rd_age_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      pend_chunk_r <= '0;
      pend_slot_r  <= '0;
      pend_off_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      if (cmd.clr) begin
        idx_r <= '0;
      end else if (cmd.rd) begin
        idx_r <= idx_r + 1'b1;
      end
      rd_v_r   <= cmd.rd;
      rd_age_r <= cmd.age;

      // lookup pass: match, first free, first lowest count
      if (rd_v_r && !rd_age_r) begin
        if (valid_q && (tag_q == chunk) && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!valid_q && !free_r) begin
          free_r <= 1'b1;
        end
      end

      if (age_we) begin
        cnt_init_r[rd_idx_r] <= 1'b1;
      end

      if (cmd.resolve && !hit_r) begin
        pend_chunk_r <= chunk;
        pend_slot_r  <= victim;
        pend_off_r   <= offset;
        pend_valid_r <= 1'b1;
      end

      if (cmd.fill) begin
        tag_valid_r[pend_slot_r] <= 1'b1;
        cnt_init_r[pend_slot_r]  <= 1'b1;
        pend_valid_r             <= 1'b0;
      end

      if (cmd.inval) begin
        tag_valid_r <= '0;
      end
      if (cmd.drop_pend) begin
        pend_valid_r <= 1'b0;
      end

      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_tuser;
      sector_r <= in_tdata[SECTOR_W-1:0];
      ok_r     <= in_tdata[SECTOR_W];
    end
    if (cmd.rd) begin
      rd_idx_r   <= idx_r;
      cnt_init_q <= cnt_init_r[idx_r];
      valid_q    <= tag_valid_r[idx_r];
    end
    if (rd_v_r && !rd_age_r) begin
      if (valid_q && (tag_q == chunk) && !hit_r) begin
        hit_slot_r <= rd_idx_r;
      end
      if (!valid_q && !free_r) begin
        free_slot_r <= rd_idx_r;
      end
      if ((rd_idx_r == '0) || (cnt_cur < min_r)) begin
        min_r      <= cnt_cur;
        min_slot_r <= rd_idx_r;
      end
    end
    if (cmd.resolve) begin
      res_off_r <= offset;
      if (hit_r) begin
        res_oc_r    <= OC_HIT;
        res_slot_r  <= hit_slot_r;
        res_start_r <= '0;
        res_cnt_r   <= '0;
      end else begin
        res_oc_r    <= OC_MISS;
        res_slot_r  <= victim;
        res_start_r <= miss_start;
        res_cnt_r   <= miss_cnt;
      end
    end
    if (cmd.fill) begin
      res_oc_r    <= OC_FILL;
      res_slot_r  <= pend_slot_r;
      res_off_r   <= pend_off_r;
      res_start_r <= '0;
      res_cnt_r   <= '0;
    end
    if (cmd.inval) begin
      res_oc_r    <= OC_INVAL;
      res_slot_r  <= '0;
      res_off_r   <= '0;
      res_start_r <= '0;
      res_cnt_r   <= '0;
    end
    if (cmd.push) begin
      out_user_r <= res_oc_r;
      out_data_r <= {1'b0, res_cnt_r, res_start_r, res_off_r, SLOT_W'(res_slot_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sts.req        = req_r;
  assign sts.read_ok    = ok_r;
  assign sts.pend_valid = pend_valid_r;
  assign sts.idx_last   = (idx_r == IDX_LAST);
  assign sts.hit        = hit_r;
  assign sts.can_push   = !out_valid_r || out_tready;

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |=> tag_valid_r[$past(pend_slot_r)])
    else $error("fill did not mark its slot valid");

  a_fill_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |=> !pend_valid_r)
    else $error("pending request survived a fill");

  a_inval_clears_all: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.inval |=> (tag_valid_r == '0))
    else $error("tags still valid after invalidation");

  a_miss_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && !hit_r) |=> (pend_valid_r && (pend_slot_r == res_slot_r)))
    else $error("miss did not record its pending slot");

  a_push_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_tready))
    else $error("result pushed over an unread word");

endmodule

>>> rtl/core/sector_chunk_cache_policy.sv
// tag and replacement policy for a cache of 16-sector chunks
// input stream: in_tuser carries the request kind (lookup, fill completion,
//   invalidate all), in_tdata carries the sector and the fill status
// result stream: one word per lookup, per fill with a pending miss and per
//   invalidate; a fill with nothing pending and an unknown kind give no word
// config: one apb register at address 0, the volume size in sectors
//   (zero disables clipping of the read count)
// sequencing: a lookup scans the tag and count stores one slot per cycle through
//   their read port, and a hit then runs an aging pass over all slots; a fill,
//   a failed fill or an invalidate needs no scan
// throughput: one word at a time; the next word is accepted the cycle
//   after the previous result enters the output register
// the output register holds one finished word, so a new word is taken
//   while the receiver stalls; the block then waits with its next result
//   until that word is taken
// reset: all tags invalid, all use counts zero, no pending miss, volume
//   size zero
module sector_chunk_cache_policy #(
  parameter int SLOTS       = scc_pkg::SLOTS_DEF,
  parameter int COUNT_WIDTH = scc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] sector, [32] read_ok, [39:33] zero
  input  logic [scc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [scc_pkg::REQ_W-1:0]       in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [5:0] slot, [9:6] offset_in_chunk, [41:10] read_start,
  // [46:42] read_count, [47] zero
  output logic [scc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] outcome
  output logic [scc_pkg::OC_W-1:0]        out_tuser,
  // config port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import scc_pkg::*;

  // register index taken from the word address
  localparam logic REG_VOLUME = 1'b0;

  cmd_t cmd;
  sts_t sts;

  logic [SECTOR_W-1:0] volume_r;
  logic                cfg_wr;

  // apb: no wait states, writes land in the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_VOLUME)) begin
      volume_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_VOLUME) ? volume_r : '0;

  // sequencing of the scan, aging pass and result hand-off
  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tag store, use counts, victim choice and output register
  scc_dp #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .volume_sectors (volume_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser)
  );

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;

  // register map: one register, the volume size in sectors
  localparam logic [2:0] REG_VOLUME = 3'd0;

  // a request kind the block ignores
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // cycles to let pass after the last result, longest latency plus margin
  localparam int DRAIN_TAIL = 2*SLOTS + 10;

  // words per random phase, and the hard stop of the run in ns
  localparam int PHASE_WORDS = 250;
  localparam int RUN_LIMIT   = 10_000_000;

  // one result word, field by field
  typedef struct packed {
    logic [OC_W-1:0]   outcome;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
    logic [31:0]       start;
    logic [RCNT_W-1:0] count;
  } cache_result_t;

  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t         kind;
    logic [31:0]       vol;
    logic [REQ_W-1:0]  req;
    logic [31:0]       sector;
    logic              ok;
    bit                typed;
    cache_result_t     want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] sector, [32] read_ok, [39:33] zero
  logic [REQ_W-1:0]       in_tuser;   // [1:0] req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [5:0] slot, [9:6] offset, [41:10] start,
                                      // [46:42] count, [47] zero
  logic [OC_W-1:0]        out_tuser;  // [1:0] outcome
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [2:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  sector_chunk_cache_policy u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // shadow of the tag store, use counts, pending miss and volume size
  // ---------------------------------------------------------------------
  logic [CHUNK_W-1:0]     shadow_tag [SLOTS];
  logic                   shadow_live [SLOTS];
  logic [COUNT_WIDTH-1:0] shadow_uses [SLOTS];
  logic [CHUNK_W-1:0]     miss_chunk;
  int                     miss_slot;
  logic [OFF_W-1:0]       miss_offset;
  logic                   miss_open;
  logic [31:0]            vol_sectors;

  cache_result_t due_results [$];   // words the block still owes, oldest first

  int  mismatches;
  int  words_made;
  int  words_ignored;
  int  tally [4];                   // results per outcome
  int  vol_settings;
  int  burst_left;
  bit  tight_send;                  // no sender gaps
  bit  rx_open;                     // receiver never stalls

  // receiver stall pattern
  int  rx_left;
  int  rx_mode;
  int  rx_run;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 40)
      $display("%0t ns: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // cache policy predictor: returns 1 when the request yields a word
  function automatic bit policy_predict(input logic [REQ_W-1:0] req,
                                        input logic [31:0] sector,
                                        input logic ok,
                                        output cache_result_t r);
    logic [CHUNK_W-1:0] chunk;
    logic [OFF_W-1:0]   off;
    logic [31:0]        start;
    int                 hit_at;
    int                 pick;
    chunk = sector[31:4];
    off   = sector[3:0];
    r     = '0;
    case (req)
      REQ_LOOKUP: begin
        hit_at = -1;
        for (int i = 0; i < SLOTS; i++)
          if (hit_at < 0 && shadow_live[i] && shadow_tag[i] == chunk) hit_at = i;
        if (hit_at >= 0) begin
          // hit slot ages up (saturating), every other nonzero count down
          for (int j = 0; j < SLOTS; j++) begin
            if (j == hit_at) begin
              if (shadow_uses[j] != {COUNT_WIDTH{1'b1}}) shadow_uses[j]++;
            end else if (shadow_uses[j] != 0) begin
              shadow_uses[j]--;
            end
          end
          r.outcome = OC_HIT;
          r.slot    = SLOT_W'(hit_at);
          r.offset  = off;
          return 1'b1;
        end
        // victim: first free slot, else first of the lowest count
        pick = -1;
        for (int i = 0; i < SLOTS; i++)
          if (pick < 0 && !shadow_live[i]) pick = i;
        if (pick < 0) begin
          pick = 0;
          for (int i = 1; i < SLOTS; i++)
            if (shadow_uses[i] < shadow_uses[pick]) pick = i;
        end
        start   = {chunk, 4'h0};
        r.count = CHUNK_LEN;
        if (vol_sectors != 0) begin
          if (vol_sectors <= start) r.count = '0;
          else if (vol_sectors - start < 32'd16) r.count = RCNT_W'(vol_sectors - start);
        end
        miss_chunk  = chunk;
        miss_slot   = pick;
        miss_offset = off;
        miss_open   = 1'b1;
        r.outcome   = OC_MISS;
        r.slot      = SLOT_W'(pick);
        r.offset    = off;
        r.start     = start;
        return 1'b1;
      end
      REQ_FILL: begin
        if (!miss_open) return 1'b0;
        miss_open = 1'b0;
        if (ok) begin
          shadow_tag[miss_slot]  = miss_chunk;
          shadow_live[miss_slot] = 1'b1;
          shadow_uses[miss_slot] = COUNT_WIDTH'(FILL_COUNT);
          r.outcome = OC_FILL;
          r.slot    = SLOT_W'(miss_slot);
          r.offset  = miss_offset;
        end else begin
          // failed read drops every tag, counts stay
          for (int i = 0; i < SLOTS; i++) shadow_live[i] = 1'b0;
          r.outcome = OC_INVAL;
        end
        return 1'b1;
      end
      REQ_INVAL: begin
        for (int i = 0; i < SLOTS; i++) shadow_live[i] = 1'b0;
        r.outcome = OC_INVAL;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // input side: one word per call, bursts with random gaps in between
  // returns right after the accepting edge
  // ---------------------------------------------------------------------
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [31:0] sector,
                           input logic ok, output bit made, output cache_result_t res);
    int gap;
    @(negedge clk);
    if (!tight_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_tvalid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {7'd0, ok, sector};
    do @(posedge clk); while (!in_tready);
    made = policy_predict(req, sector, ok, res);
    if (made) begin
      due_results.push_back(res);
      tally[res.outcome]++;
      words_made++;
    end else begin
      words_ignored++;
    end
  endtask

  // hold off input until every owed word is out and the block is quiet
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // apb write of the volume size, then read it back
  task automatic set_volume(input logic [31:0] v);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = REG_VOLUME;
    cfg_pwdata  = v;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    vol_sectors = v;
    vol_settings++;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== v) note_mismatch("volume readback", cfg_prdata, v);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  function automatic plan_row_t word_row(input logic [REQ_W-1:0] req,
                                         input logic [31:0] sector, input logic ok);
    plan_row_t row;
    row        = '{kind: ROW_WORD, default: '0};
    row.req    = req;
    row.sector = sector;
    row.ok     = ok;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic [REQ_W-1:0] req,
                                          input logic [31:0] sector, input logic ok,
                                          input logic [OC_W-1:0] oc,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [OFF_W-1:0] off,
                                          input logic [31:0] start,
                                          input logic [RCNT_W-1:0] cnt);
    plan_row_t row;
    row       = word_row(req, sector, ok);
    row.typed = 1'b1;
    row.want  = '{outcome: oc, slot: slot, offset: off, start: start, count: cnt};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [31:0] v);
    plan_row_t row;
    row      = '{kind: ROW_CFG, default: '0};
    row.vol  = v;
    return row;
  endfunction

  // ---------------------------------------------------------------------
  // receiver: stretches of always ready, coin flips and long stalls
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    if (rx_open || rx_mode == 0) begin
      out_tready <= 1'b1;
    end else if (rx_mode == 1) begin
      out_tready <= 1'($urandom_range(0, 1));
    end else if (rx_run == 0) begin
      out_tready <= 1'b1;
      rx_run = $urandom_range(1, 20);
    end else begin
      out_tready <= 1'b0;
      rx_run--;
    end
  end

  // ---------------------------------------------------------------------
  // result checker: every taken word against the oldest owed word
  // ---------------------------------------------------------------------
  cache_result_t seen_word;
  cache_result_t owed_word;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word = '{outcome: out_tuser, slot: out_tdata[5:0], offset: out_tdata[9:6],
                    start: out_tdata[41:10], count: out_tdata[46:42]};
      if (due_results.size() == 0) begin
        note_mismatch("word with nothing owed, outcome", 32'(seen_word.outcome), 0);
      end else begin
        owed_word = due_results.pop_front();
        if (seen_word.outcome !== owed_word.outcome)
          note_mismatch("outcome", 32'(seen_word.outcome), 32'(owed_word.outcome));
        if (seen_word.slot !== owed_word.slot)
          note_mismatch("slot", 32'(seen_word.slot), 32'(owed_word.slot));
        if (seen_word.offset !== owed_word.offset)
          note_mismatch("offset_in_chunk", 32'(seen_word.offset), 32'(owed_word.offset));
        if (seen_word.start !== owed_word.start)
          note_mismatch("read_start", seen_word.start, owed_word.start);
        if (seen_word.count !== owed_word.count)
          note_mismatch("read_count", 32'(seen_word.count), 32'(owed_word.count));
      end
    end
  end

  // hard stop
  initial begin
    #RUN_LIMIT;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  plan_row_t plan [$];

  initial begin
    bit                 made;
    cache_result_t      res;
    logic [CHUNK_W-1:0] base;
    logic [CHUNK_W-1:0] hot_chunk;
    logic [31:0]        vol;
    logic [31:0]        sector;
    int                 dice;
    int                 k;
    int                 phase_start;
    int                 waited;

    // every input known from time zero
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_LOOKUP;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = REG_VOLUME;
    cfg_pwdata  = '0;
    mismatches  = 0;
    words_made  = 0;
    words_ignored = 0;
    vol_settings  = 0;
    burst_left  = 0;
    tight_send  = 1'b0;
    rx_open     = 1'b0;
    rx_left     = 0;
    rx_mode     = 0;
    rx_run      = 0;
    foreach (tally[i]) tally[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i]  = '0;
      shadow_live[i] = 1'b0;
      shadow_uses[i] = '0;
    end
    miss_chunk  = '0;
    miss_slot   = 0;
    miss_offset = '0;
    miss_open   = 1'b0;
    vol_sectors = '0;

    // directed table: reset state, sector extremes, every request kind,
    // replaced pending miss, fill with nothing pending, clipping at the end
    plan.push_back(typed_row(REQ_LOOKUP, 32'h0, 1'b0, OC_MISS, 0, 0, 32'h0, 16));
    plan.push_back(typed_row(REQ_FILL, 32'h0, 1'b1, OC_FILL, 0, 0, 32'h0, 0));
    plan.push_back(typed_row(REQ_LOOKUP, 32'h5, 1'b0, OC_HIT, 0, 5, 32'h0, 0));
    plan.push_back(typed_row(REQ_LOOKUP, 32'hFFFFFFFF, 1'b0, OC_MISS, 1, 15,
                             32'hFFFFFFF0, 16));
    // a second miss replaces the pending one
    plan.push_back(typed_row(REQ_LOOKUP, 32'h10, 1'b0, OC_MISS, 1, 0, 32'h10, 16));
    plan.push_back(typed_row(REQ_FILL, 32'h0, 1'b1, OC_FILL, 1, 0, 32'h0, 0));
    // nothing pending, and an unknown kind: both give no word
    plan.push_back(word_row(REQ_FILL, 32'h0, 1'b1));
    plan.push_back(word_row(REQ_UNKNOWN, 32'hFFFFFFFF, 1'b1));
    plan.push_back(typed_row(REQ_INVAL, 32'h0, 1'b0, OC_INVAL, 0, 0, 32'h0, 0));
    plan.push_back(typed_row(REQ_LOOKUP, 32'h0, 1'b0, OC_MISS, 0, 0, 32'h0, 16));
    // failed read drops all tags
    plan.push_back(typed_row(REQ_FILL, 32'h0, 1'b0, OC_INVAL, 0, 0, 32'h0, 0));
    plan.push_back(typed_row(REQ_LOOKUP, 32'h23, 1'b0, OC_MISS, 0, 3, 32'h20, 16));
    plan.push_back(typed_row(REQ_FILL, 32'h0, 1'b1, OC_FILL, 0, 3, 32'h0, 0));
    // small volume: past the end, then a partial chunk
    plan.push_back(cfg_row(32'd37));
    plan.push_back(typed_row(REQ_LOOKUP, 32'h3A, 1'b0, OC_MISS, 1, 10, 32'h30, 0));
    plan.push_back(typed_row(REQ_INVAL, 32'h0, 1'b0, OC_INVAL, 0, 0, 32'h0, 0));
    plan.push_back(typed_row(REQ_LOOKUP, 32'h24, 1'b0, OC_MISS, 0, 4, 32'h20, 5));
    plan.push_back(typed_row(REQ_LOOKUP, 32'h25, 1'b0, OC_MISS, 0, 5, 32'h20, 5));
    // largest volume, and a volume ending right at a chunk start
    plan.push_back(cfg_row(32'hFFFFFFFF));
    plan.push_back(typed_row(REQ_LOOKUP, 32'hFFFFFFFF, 1'b0, OC_MISS, 0, 15,
                             32'hFFFFFFF0, 15));
    plan.push_back(cfg_row(32'hFFFFFFF0));
    plan.push_back(typed_row(REQ_LOOKUP, 32'hFFFFFFF5, 1'b0, OC_MISS, 0, 5,
                             32'hFFFFFFF0, 0));
    plan.push_back(cfg_row(32'h0));
    plan.push_back(word_row(REQ_FILL, 32'h0, 1'b1));

    // hold the synchronous reset, then release it
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        set_volume(plan[i].vol);
      end else begin
        send_word(plan[i].req, plan[i].sector, plan[i].ok, made, res);
        if (plan[i].typed) begin
          // the table's word replaces the predicted one
          if (made) void'(due_results.pop_back());
          due_results.push_back(plan[i].want);
        end
      end
    end

    // eviction by lowest count: one hot chunk gets a run of hits, then the
    // other slots fill so the victim choice has to skip the hot slot
    drain_results();
    tight_send = 1'b1;
    rx_open    = 1'b1;
    hot_chunk  = 28'h0ABCDEF;
    send_word(REQ_INVAL, 32'h0, 1'b0, made, res);
    send_word(REQ_LOOKUP, {hot_chunk, 4'h0}, 1'b0, made, res);
    send_word(REQ_FILL, 32'h0, 1'b1, made, res);
    repeat (8)
      send_word(REQ_LOOKUP, {hot_chunk, 4'($urandom)}, 1'b0, made, res);
    for (int i = 1; i <= SLOTS; i++) begin
      send_word(REQ_LOOKUP, {hot_chunk + CHUNK_W'(i), 4'($urandom)}, 1'b0, made, res);
      send_word(REQ_FILL, 32'h0, 1'b1, made, res);
    end
    drain_results();
    tight_send = 1'b0;
    rx_open    = 1'b0;

    // random phases, each with its own volume size and pool of chunks;
    // a small pool against few slots keeps hits and evictions frequent
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          base = CHUNK_W'($urandom_range(0, 28'hFFFFFF0));
          vol  = 32'h0;
        end
        1: begin
          base = CHUNK_W'($urandom_range(0, 64));
          vol  = {base, 4'h0} + $urandom_range(0, 200);
        end
        2: begin
          base = 28'hFFFFFF4;
          vol  = 32'hFFFFFFFF;
        end
        default: begin
          base = CHUNK_W'($urandom_range(0, 28'hFFFFFF0));
          vol  = {base, 4'h0} + $urandom_range(0, 200);
        end
      endcase
      drain_results();
      set_volume(vol);
      phase_start = words_made;
      while (words_made - phase_start < PHASE_WORDS) begin
        dice = $urandom_range(0, 99);
        if (dice < 72 || dice >= 94) begin
          // lookups: pool chunk, live tag or any sector
          if (dice >= 94) begin
            k = $urandom_range(0, SLOTS - 1);
            sector = shadow_live[k] ? {shadow_tag[k], 4'($urandom)}
                                    : {base + CHUNK_W'($urandom_range(0, 11)), 4'($urandom)};
          end else if (dice < 60) begin
            sector = {base + CHUNK_W'($urandom_range(0, 11)), 4'($urandom)};
          end else begin
            sector = $urandom;
          end
          send_word(REQ_LOOKUP, sector, 1'($urandom), made, res);
          // most misses get their fill completion, mostly successful
          if (made && res.outcome == OC_MISS && $urandom_range(0, 9) < 8)
            send_word(REQ_FILL, $urandom, ($urandom_range(0, 9) != 0), made, res);
        end else if (dice < 82) begin
          send_word(REQ_FILL, $urandom, 1'($urandom), made, res);
        end else if (dice < 90) begin
          send_word(REQ_INVAL, $urandom, 1'($urandom), made, res);
        end else begin
          send_word(REQ_UNKNOWN, $urandom, 1'($urandom), made, res);
        end
        // now and then hold off until everything owed has come back
        if ($urandom_range(0, 299) == 0) drain_results();
      end
    end

    // wind down
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    if (due_results.size() != 0)
      note_mismatch("words never delivered", due_results.size(), 0);
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("covered %0d words with a result (%0d hits, %0d misses, %0d fills, %0d drops)",
             words_made, tally[OC_HIT], tally[OC_MISS], tally[OC_FILL], tally[OC_INVAL]);
    $display("plus %0d ignored words, %0d volume settings, lowest-count eviction",
             words_ignored, vol_settings);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/scc_pkg.sv
rtl/core/scc_ctrl.sv
rtl/core/scc_dp.sv
rtl/core/sector_chunk_cache_policy.sv
bench/tb_top.sv
